@@ src/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

@@ src/tpvb_pkg.sv @@
package tpvb_pkg;

  localparam int CLOSE_W    = 32;
  localparam int Q_W        = 48;
  localparam int FEE_W      = 32;
  localparam int GAMMA_W    = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FEE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 1'b1;

  localparam logic [FEE_W-1:0]   FEE_RESET   = 32'd4294967;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 17'd65536;

  // Quotient bits kept; larger ratios saturate.
  localparam int DIV_STEPS = 47;
  localparam int SAT_SHIFT = DIV_STEPS - CLOSE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [CLOSE_W-1:0] close_price;
    logic               series_start;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] q_flat_hold;
    logic signed [Q_W-1:0] q_flat_buy;
    logic signed [Q_W-1:0] q_flat_sell;
    logic signed [Q_W-1:0] q_long_hold;
    logic signed [Q_W-1:0] q_long_buy;
    logic signed [Q_W-1:0] q_long_sell;
    logic signed [Q_W-1:0] best_flat;
    logic signed [Q_W-1:0] best_long;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL_FLAT,
    S_MUL_LONG,
    S_SUM,
    S_MAX
  } state_t;

  typedef struct packed {
    logic load_start;
    logic div_init;
    logic div_step;
    logic mul_en;
    logic mul_long;
    logic sum_en;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

@@ src/tpvb_ctrl.sv @@
module tpvb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_start,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output tpvb_pkg::cmd_t    cmd,
  input  tpvb_pkg::status_t status
);
  import tpvb_pkg::*;

  state_t state_r, state_nxt;
  logic   have_later_r, have_later_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      have_later_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      have_later_r <= have_later_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    have_later_nxt = have_later_r;
    cmd            = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_start || !have_later_r) begin
            cmd.load_start = 1'b1;
            have_later_nxt = 1'b1;
          end else begin
            cmd.div_init = 1'b1;
            state_nxt    = S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = S_MUL_FLAT;
        end
      end
      S_MUL_FLAT: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_MUL_LONG;
      end
      S_MUL_LONG: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_long = 1'b1;
        state_nxt    = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_MAX;
      end
      S_MAX: begin
        // wait for the output slot to free up
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ src/tpvb_dp.sv @@
module tpvb_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [tpvb_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [tpvb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  tpvb_pkg::in_item_t                  in_data,
  input  tpvb_pkg::cmd_t                      cmd,
  output tpvb_pkg::status_t                   status,
  output tpvb_pkg::out_item_t                 out_data
);
  import tpvb_pkg::*;

  localparam int PROD_W = Q_W + GAMMA_W + 1;
  localparam int DISC_W = PROD_W - 16;
  localparam int SUM_W  = DISC_W + 2;
  localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(64'sd4294967296);
  localparam logic [DIV_STEPS-1:0]    RATIO_MAX = '1;

  // config
  logic [FEE_W-1:0]   fee_r;
  logic [GAMMA_W-1:0] gamma_r;

  // carried state
  logic [CLOSE_W-1:0]    later_close_r;
  logic signed [Q_W-1:0] value_flat_r, value_long_r;

  // divider
  logic [CLOSE_W-1:0]   cur_close_r;
  logic [CLOSE_W-1:0]   rem_r;
  logic [SAT_SHIFT-1:0] dsh_r;
  logic [DIV_STEPS-1:0] quo_r;
  logic                 sat_r;
  logic [DIV_CNT_W-1:0] cnt_r;

  // discount and sums
  logic signed [DISC_W-1:0] df_r, dl_r;
  logic signed [Q_W-1:0]    fh_r, fb_r, lh_r, ls_r;
  out_item_t                out_r;

  logic [CLOSE_W:0]          shifted;
  logic                      ge;
  logic [CLOSE_W:0]          diff;
  logic signed [Q_W-1:0]     mul_a;
  logic signed [PROD_W-1:0]  prod;
  logic [DIV_STEPS-1:0]      ratio;
  logic signed [SUM_W-1:0]   ret_s, fee_s, df_s, dl_s;
  logic signed [Q_W-1:0]     best_f, best_l;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-Q_W:0] top;
    top = x[SUM_W-1:Q_W-1];
    if (top == '0 || top == '1) begin
      return x[Q_W-1:0];
    end else if (x[SUM_W-1]) begin
      return {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fee_r   <= FEE_RESET;
      gamma_r <= GAMMA_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FEE:   fee_r   <= cfg_wdata[FEE_W-1:0];
        REG_GAMMA: gamma_r <= cfg_wdata[GAMMA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      later_close_r <= '0;
      value_flat_r  <= '0;
      value_long_r  <= '0;
    end else if (cmd.load_start) begin
      later_close_r <= in_data.close_price;
      value_flat_r  <= '0;
      value_long_r  <= '0;
    end else if (cmd.commit) begin
      later_close_r <= cur_close_r;
      value_flat_r  <= best_f;
      value_long_r  <= best_l;
    end
  end

  // restoring divide: one quotient bit per step, remainder stays below close
  assign shifted = {rem_r, dsh_r[SAT_SHIFT-1]};
  assign ge      = (shifted >= {1'b0, cur_close_r});
  assign diff    = shifted - {1'b0, cur_close_r};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      cur_close_r <= in_data.close_price;
      rem_r       <= {{SAT_SHIFT{1'b0}}, later_close_r[CLOSE_W-1:SAT_SHIFT]};
      dsh_r       <= later_close_r[SAT_SHIFT-1:0];
      // ratio would reach 2^47, or close is zero
      sat_r       <= ({{SAT_SHIFT{1'b0}}, later_close_r} >=
                      {in_data.close_price, {SAT_SHIFT{1'b0}}});
      cnt_r       <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? diff[CLOSE_W-1:0] : shifted[CLOSE_W-1:0];
      dsh_r <= {dsh_r[SAT_SHIFT-2:0], 1'b0};
      quo_r <= {quo_r[DIV_STEPS-2:0], ge};
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  assign status.div_last = (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));

  // shared multiplier, floor(gamma * v / 2^16)
  assign mul_a = cmd.mul_long ? value_long_r : value_flat_r;
  assign prod  = PROD_W'(mul_a) * PROD_W'($signed({1'b0, gamma_r}));

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      if (cmd.mul_long) begin
        dl_r <= prod[PROD_W-1:16];
      end else begin
        df_r <= prod[PROD_W-1:16];
      end
    end
  end

  assign ratio = sat_r ? RATIO_MAX : quo_r;
  assign ret_s = $signed({{(SUM_W-DIV_STEPS){1'b0}}, ratio}) - ONE_SUM;
  assign fee_s = $signed({{(SUM_W-FEE_W){1'b0}}, fee_r});
  assign df_s  = SUM_W'(df_r);
  assign dl_s  = SUM_W'(dl_r);

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      fh_r <= sat_q(df_s);
      fb_r <= sat_q(ret_s - fee_s + dl_s);
      lh_r <= sat_q(ret_s + dl_s);
      ls_r <= sat_q(df_s - fee_s);
    end
  end

  assign best_f = (fb_r > fh_r) ? fb_r : fh_r;
  assign best_l = (ls_r > lh_r) ? ls_r : lh_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.q_flat_hold <= fh_r;
      out_r.q_flat_buy  <= fb_r;
      out_r.q_flat_sell <= fh_r;
      out_r.q_long_hold <= lh_r;
      out_r.q_long_buy  <= lh_r;
      out_r.q_long_sell <= ls_r;
      out_r.best_flat   <= best_f;
      out_r.best_long   <= best_l;
    end
  end

  assign out_data = out_r;

endmodule

@@ src/trade_position_value_backup_top.sv @@
// A series-start item (or the first item after reset) is loaded straight from IDLE, no result.
// Any other item runs the divide, multiplies, sums and max, then raises out_valid.
// New items wait for IDLE; the divide loop runs 47 steps at one quotient bit per cycle.
// The result register frees the output side; the next item starts while a result waits.
// Reset: rst_n synchronous, active low; clears control, values, fee to 4294967, gamma to 1.0.
module trade_position_value_backup_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [tpvb_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [tpvb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // candle requests, newest first
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tpvb_pkg::in_item_t              in_data,
  // action value requests
  output logic                            out_valid,
  input  logic                            out_stall,
  output tpvb_pkg::out_item_t             out_data
);
  import tpvb_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: IDLE -> DIV (47 steps) -> MUL_FLAT -> MUL_LONG -> SUM -> MAX.
  // Series-start requests load the close and zero the values straight from IDLE.
  tpvb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_start  (in_data.series_start),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath: restoring divider for later/current, one shared 48x17 multiplier
  // for the gamma discount, saturating sums, then the per-position max into
  // the result register.
  tpvb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

@@ src/tpvb_checker.sv @@
`include "assert_macros.svh"

module tpvb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_we,
  input logic                            in_valid,
  input logic                            in_stall,
  input tpvb_pkg::in_item_t              in_data,
  input logic                            out_valid,
  input logic                            out_stall,
  input tpvb_pkg::out_item_t             out_data
);
  import tpvb_pkg::*;

  logic in_acc;
  logic start_acc;

  assign in_acc    = in_valid && !in_stall;
  assign start_acc = in_acc && in_data.series_start;

  // a series start never occupies the block
  `ASSERT_NEXT(a_start_one_cycle, clk, rst_n, start_acc, !in_stall)
  // no result can appear right after a request is taken
  `ASSERT_NEXT(a_no_early_result, clk, rst_n, in_acc, !$rose(out_valid))
  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
               out_valid && $stable(out_data))
  // registers change only while the block is empty
  `ASSERT_IMPLIES(a_cfg_idle, clk, rst_n, cfg_we, !in_stall && !out_valid)

endmodule

bind trade_position_value_backup_top tpvb_checker u_tpvb_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import tpvb_pkg::*;

  // Fixed-point limits of the Q15.32 result fields.
  localparam longint Q_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint Q_MIN = -Q_MAX - 1;
  localparam longint ONE_Q = 64'sh0000_0001_0000_0000;

  // Settle time before register writes and at the end of the run.
  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 154;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;

  trade_position_value_backup_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: the block's registers and its backed-up position values.
  // ---------------------------------------------------------------------------
  logic [FEE_W-1:0]      fee_setting;
  logic [GAMMA_W-1:0]    gamma_setting;
  logic [CLOSE_W-1:0]    newer_close;   // close of the previous (newer) candle
  logic signed [Q_W-1:0] flat_worth;
  logic signed [Q_W-1:0] long_worth;
  logic                  series_open;   // a series start has been seen

  // Action values still owed by the block, oldest first.
  out_item_t action_values_due [$];

  int error_count = 0;
  bit gaps_on;
  int burst_left;

  string field_names [8] = '{"q_flat_hold", "q_flat_buy", "q_flat_sell", "q_long_hold",
                             "q_long_buy", "q_long_sell", "best_flat", "best_long"};

  // ---------------------------------------------------------------------------
  // Clock and timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Slowest legal run is a few ms; this only fires on a hang.
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Arithmetic helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [Q_W-1:0] sat48(input longint x);
    longint c;
    c = x;
    if (c > Q_MAX) c = Q_MAX;
    if (c < Q_MIN) c = Q_MIN;
    return c[Q_W-1:0];
  endfunction

  // gamma * v / 2^16, rounded toward minus infinity, exact in 64 bits.
  function automatic longint discount_q(input longint v);
    longint unsigned mag;
    longint unsigned prod;
    if (v >= 0) begin
      prod = longint'(v) * longint'({47'd0, gamma_setting});
      return longint'(prod >> 16);
    end
    mag = longint'(-v);
    prod = mag * longint'({47'd0, gamma_setting});
    return -longint'((prod + 64'h0000_0000_0000_FFFF) >> 16);
  endfunction

  // One step of the backward pass. Updates the predictor state and tells
  // whether the request yields a result, and if so what it is.
  function automatic void back_up_values(input in_item_t req, output bit produces,
                                         output out_item_t want);
    longint unsigned ratio;
    longint ret;
    longint fee_q;
    longint dflat;
    longint dlong;
    logic signed [Q_W-1:0] f_hold, f_buy, l_hold, l_sell, b_flat, b_long;
    produces = 1'b0;
    want = '0;
    // Series start, or no series start seen yet: store close, zero values.
    if (req.series_start || !series_open) begin
      newer_close = req.close_price;
      flat_worth = '0;
      long_worth = '0;
      series_open = 1'b1;
      return;
    end
    // Zero close saturates the ratio, as does any ratio past 2^47-1.
    if (req.close_price == '0) begin
      ratio = longint'(Q_MAX);
    end else begin
      ratio = {newer_close, 32'h0} / {32'h0, req.close_price};
      if (ratio > longint'(Q_MAX)) ratio = longint'(Q_MAX);
    end
    ret   = longint'(ratio) - ONE_Q;
    fee_q = longint'({32'h0, fee_setting});
    dflat = discount_q(longint'(flat_worth));
    dlong = discount_q(longint'(long_worth));

    f_hold = sat48(dflat);
    f_buy  = sat48(ret - fee_q + dlong);
    l_hold = sat48(ret + dlong);
    l_sell = sat48(dflat - fee_q);
    b_flat = (f_buy > f_hold) ? f_buy : f_hold;
    b_long = (l_sell > l_hold) ? l_sell : l_hold;

    want = '{f_hold, f_buy, f_hold, l_hold, l_hold, l_sell, b_flat, b_long};
    produces = 1'b1;
    flat_worth = b_flat;
    long_worth = b_long;
    newer_close = req.close_price;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_error(input string msg);
    error_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic compare_values(input out_item_t got, input out_item_t want);
    logic signed [Q_W-1:0] g [8];
    logic signed [Q_W-1:0] w [8];
    g = '{got.q_flat_hold, got.q_flat_buy, got.q_flat_sell, got.q_long_hold,
          got.q_long_buy, got.q_long_sell, got.best_flat, got.best_long};
    w = '{want.q_flat_hold, want.q_flat_buy, want.q_flat_sell, want.q_long_hold,
          want.q_long_buy, want.q_long_sell, want.best_flat, want.best_long};
    for (int k = 0; k < 8; k++) begin
      if (g[k] !== w[k])
        report_error($sformatf("%s got %0d expected %0d", field_names[k], g[k], w[k]));
    end
  endtask

  // Each result request taken at a rising edge is matched against the oldest
  // expectation. Inputs change on the falling edge, so no race here.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (action_values_due.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        want = action_values_due.pop_front();
        compare_values(out_data, want);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern that switches between modes after a random
  // hold -- free-flowing, coin flip, long stretches, mostly stalled.
  // ---------------------------------------------------------------------------
  initial begin : receiver_pattern
    int mode;
    int hold;
    int stretch;
    logic level;
    out_stall = 1'b0;
    mode = 0;
    hold = 200;
    stretch = 0;
    level = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        mode = $urandom_range(0, 3);
        hold = $urandom_range(100, 600);
      end
      hold--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'($urandom_range(0, 1));
        2: begin
          if (stretch == 0) begin
            stretch = $urandom_range(1, 90);
            level = ~level;
          end
          stretch--;
          out_stall <= level;
        end
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Present one candle request and hold it until taken; valid stays high
  // afterwards so back-to-back requests need no extra edge.
  task automatic send_candle(input logic [CLOSE_W-1:0] close, input logic start);
    in_item_t req;
    bit produces;
    out_item_t want;
    req.close_price = close;
    req.series_start = start;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    back_up_values(req, produces, want);
    if (produces) action_values_due.push_back(want);
  endtask

  task automatic sender_gap(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Bursts of random length separated by gaps; long gaps now and then so
  // the pause lands on every step of the divide loop.
  task automatic pace_sender();
    if (!gaps_on) return;
    if (burst_left == 0) begin
      sender_gap(($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8));
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
  endtask

  // Stop sending, wait for every owed result, then let the block go quiet.
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (action_values_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called while idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_FEE) fee_setting = data[FEE_W-1:0];
    else if (idx == REG_GAMMA) gamma_setting = data[GAMMA_W-1:0];
  endtask

  // Next (older) close: mostly a small move from the newer one, sometimes a
  // jump anywhere or a corner value.
  function automatic logic [CLOSE_W-1:0] next_close(input logic [CLOSE_W-1:0] prev);
    logic [32:0] span;
    logic [32:0] moved;
    logic [31:0] step;
    case ($urandom_range(0, 24))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'd0;
          1: return 32'd1;
          2: return 32'hFFFF_FFFF;
          default: return $urandom_range(1, 255);
        endcase
      end
      default: begin
        if (prev < 32'd16) return $urandom_range(1, 1000);
        span = {1'b0, prev} >> $urandom_range(4, 12);
        step = $urandom_range(0, span[31:0]);
        if ($urandom_range(0, 1) == 1) begin
          moved = {1'b0, prev} + {1'b0, step};
          return moved[32] ? 32'hFFFF_FFFF : moved[31:0];
        end
        moved = {1'b0, prev} - {1'b0, step};
        return (moved[31:0] == 0) ? 32'd1 : moved[31:0];
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // First candle after reset carries no start flag: it must still open the
  // series and give nothing; the next one gives a result at reset settings.
  task automatic test_first_item_without_start();
    send_candle(32'd12345, 1'b0);
    send_candle(32'd12000, 1'b0);
    send_candle(32'd12600, 1'b0);
  endtask

  // Price corners: saturated ratio, zero close, zero newer close, max/min.
  task automatic test_price_extremes();
    send_candle(32'hFFFF_FFFF, 1'b1);
    send_candle(32'd1, 1'b0);          // ratio way past 2^47
    send_candle(32'd0, 1'b0);          // divide by zero
    send_candle(32'hFFFF_FFFF, 1'b0);  // newer close was zero: return -1.0
    send_candle(32'd1, 1'b0);
    send_candle(32'd1, 1'b1);          // start in mid-stream
    send_candle(32'hFFFF_FFFF, 1'b0);
    send_candle(32'h8000_0000, 1'b0);
  endtask

  // Register corners: no fee and zero gamma, then max fee with gamma above
  // 1.0 while alternating prices drive the values into saturation.
  task automatic test_register_extremes();
    settle_idle();
    write_reg(REG_FEE, 32'd0);
    write_reg(REG_GAMMA, 32'd0);
    send_candle(32'd1000, 1'b1);
    send_candle(32'd1100, 1'b0);
    send_candle(32'd900, 1'b0);
    settle_idle();
    write_reg(REG_FEE, 32'hFFFF_FFFF);
    write_reg(REG_GAMMA, 32'hFFFF_FFFF);   // upper bits ignored, gamma just under 2.0
    send_candle(32'hFFFF_FFFF, 1'b1);
    for (int k = 0; k < 8; k++) send_candle((k % 2 == 0) ? 32'd1 : 32'hFFFF_FFFF, 1'b0);
    settle_idle();
    write_reg(REG_FEE, FEE_RESET);
    write_reg(REG_GAMMA, {15'd0, GAMMA_RESET});
  endtask

  // Random series: each phase waits for the block to drain, picks new
  // register values, then runs price walks opened by a start request. A few
  // walks skip the start and carry on from the old state.
  task automatic test_random_series();
    logic [CLOSE_W-1:0] close;
    int sent;
    int walk_len;
    logic [CFG_DATA_W-1:0] fee_word;
    logic [CFG_DATA_W-1:0] gamma_word;
    close = 32'd10000;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_idle();
      case ($urandom_range(0, 4))
        0: fee_word = 32'd0;
        1: fee_word = 32'hFFFF_FFFF;
        2: fee_word = $urandom;
        3: fee_word = $urandom_range(0, 32'h0100_0000);
        default: fee_word = FEE_RESET;
      endcase
      case ($urandom_range(0, 4))
        0: gamma_word = 32'd0;
        1: gamma_word = $urandom | 32'h0001_FFFF;
        2: gamma_word = $urandom;
        3: gamma_word = $urandom_range(0, 65536);
        default: gamma_word = ($urandom & 32'hFFFE_0000) | 32'd65536;
      endcase
      write_reg(REG_FEE, fee_word);
      write_reg(REG_GAMMA, gamma_word);
      gaps_on = (phase % 3 != 1);
      burst_left = 0;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) != 0) begin
          close = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(100, 5_000_000);
          pace_sender();
          send_candle(close, 1'b1);
          sent++;
        end
        walk_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 40);
        for (int i = 0; i < walk_len && sent < ITEMS_PER_PHASE; i++) begin
          close = next_close(close);
          pace_sender();
          send_candle(close, 1'b0);
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    gaps_on   = 1'b0;
    burst_left = 0;
    fee_setting   = FEE_RESET;
    gamma_setting = GAMMA_RESET;
    newer_close   = '0;
    flat_worth    = '0;
    long_worth    = '0;
    series_open   = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_item_without_start();
    test_price_extremes();
    test_register_extremes();
    test_random_series();

    // Drain: anything still owed must arrive, anything extra is caught.
    settle_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
